>>> src/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication form
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

>>> src/crdg_pkg.sv
package crdg_pkg;

  // pixel index bits taken from the 12-bit fields
  localparam int COORD_BITS = 12;
  localparam int PIX_BITS   = (COORD_BITS < 12) ? COORD_BITS : 12;
  localparam int U_BITS     = PIX_BITS + 16;

  localparam int MAG_BITS   = 32;
  localparam int SQRT_STEPS = 32;
  localparam int QUO_BITS   = 15;

  // register indexes
  localparam logic [2:0] REG_X_SCALE = 3'd0;
  localparam logic [2:0] REG_Y_SCALE = 3'd1;
  localparam logic [2:0] REG_ASPECT  = 3'd2;
  localparam logic [2:0] REG_FOCAL   = 3'd3;
  localparam logic [2:0] REG_ROT_X   = 3'd4;
  localparam logic [2:0] REG_ROT_Y   = 3'd5;
  localparam logic [2:0] REG_ROT_Z   = 3'd6;

  localparam logic [24:0] X_SCALE_RST = 25'd32768;
  localparam logic [24:0] Y_SCALE_RST = 25'd32768;
  localparam logic [19:0] ASPECT_RST  = 20'd65536;
  localparam logic [19:0] FOCAL_RST   = 20'd65536;
  localparam logic [47:0] ROT_X_RST   = 48'h0000_0000_4000;
  localparam logic [47:0] ROT_Y_RST   = 48'h0000_4000_0000;
  localparam logic [47:0] ROT_Z_RST   = 48'h4000_0000_0000;

  // magnitudes with their signs and an all-zero mark
  typedef struct packed {
    logic [2:0][MAG_BITS-1:0] mag;
    logic [2:0]               neg;
    logic                     zero;
  } vec_t;

  typedef logic [2:0][15:0] dir_t;
  typedef logic [2:0][47:0] rot_t;

endpackage

>>> src/crdg_screen.sv
module crdg_screen import crdg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [11:0] pixel_x,
  input  logic [11:0] pixel_y,
  input  logic [15:0] jitter_x,
  input  logic [15:0] jitter_y,
  input  logic [24:0] x_scale,
  input  logic [24:0] y_scale,
  input  logic [19:0] aspect_ratio,
  input  logic [19:0] focal_depth,
  output logic        out_valid,
  output vec_t        out_vec
);

  localparam int PROD_BITS = U_BITS + 25;
  localparam int T_BITS    = PROD_BITS - 24;
  localparam int S_BITS    = T_BITS + 1;
  localparam int PA_BITS   = S_BITS + 21;

  localparam logic [PROD_BITS-1:0]     RND24   = PROD_BITS'(64'd8388608);
  localparam logic signed [S_BITS-1:0] ONE_Q16 = S_BITS'(64'sd65536);
  localparam logic signed [PA_BITS-1:0] RND16  = PA_BITS'(64'sd32768);
  localparam logic signed [PA_BITS-1:0] I32_HI = PA_BITS'(64'sd2147483647);
  localparam logic signed [PA_BITS-1:0] I32_LO = -I32_HI - PA_BITS'(64'sd1);

  logic [4:0] valid;

  logic [U_BITS-1:0]    ux, uy;
  logic [PROD_BITS-1:0] prod_x, prod_y;
  logic [T_BITS-1:0]    tx, ty;
  logic signed [S_BITS-1:0]  sx, sy, sy3;
  logic signed [PA_BITS-1:0] pxa, fx_rnd;
  logic signed [31:0] fx, fy;

  assign ux = {pixel_x[PIX_BITS-1:0], jitter_x};
  assign uy = {pixel_y[PIX_BITS-1:0], jitter_y};
  assign tx = T_BITS'((prod_x + RND24) >> 24);
  assign ty = T_BITS'((prod_y + RND24) >> 24);
  assign fx_rnd = (pxa + RND16) >>> 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // scale multiply
      prod_x <= ux * x_scale;
      prod_y <= uy * y_scale;
      // round and recenter
      sx <= $signed({1'b0, tx}) - ONE_Q16;
      sy <= $signed({1'b0, ty}) - ONE_Q16;
      // aspect multiply
      pxa <= sx * $signed({1'b0, aspect_ratio});
      sy3 <= sy;
      // round and saturate
      if (fx_rnd > I32_HI) begin
        fx <= 32'(I32_HI);
      end else if (fx_rnd < I32_LO) begin
        fx <= 32'(I32_LO);
      end else begin
        fx <= 32'(fx_rnd);
      end
      fy <= 32'(sy3);
      // magnitudes and signs
      out_vec.mag[0] <= fx[31] ? (~fx + 32'd1) : fx;
      out_vec.mag[1] <= fy[31] ? (~fy + 32'd1) : fy;
      out_vec.mag[2] <= 32'(focal_depth);
      out_vec.neg    <= {focal_depth != 20'd0, fy[31], fx[31]};
      out_vec.zero   <= (fx == 32'd0) && (fy == 32'd0) && (focal_depth == 20'd0);
    end
  end

  assign out_valid = valid[4];

endmodule

>>> src/crdg_sqrt.sv
module crdg_sqrt import crdg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  vec_t                in_vec,
  output logic                out_valid,
  output vec_t                out_vec,
  output logic [MAG_BITS-1:0] out_norm
);

  // left shift that brings the largest magnitude to bit 30 or 31
  function automatic logic [4:0] norm_shift(logic [31:0] w);
    logic [4:0] sh;
    sh = 5'd0;
    for (int i = 0; i < 30; i++) begin
      if (w[i]) sh = 5'(30 - i);
    end
    // already at bit 30 or above, no shift
    if (w[31:30] != 2'b00) sh = 5'd0;
    return sh;
  endfunction

  logic [2:0] pre_valid;
  vec_t       v1, v2, v3;
  logic [4:0] sh;
  logic [2:0][63:0] sq;

  logic [SQRT_STEPS:0] valid;
  vec_t        vp   [0:SQRT_STEPS];
  logic [63:0] remp [0:SQRT_STEPS-1];
  logic [63:0] resp [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_valid <= '0;
      valid     <= '0;
    end else if (en) begin
      pre_valid <= {pre_valid[1:0], in_valid};
      valid     <= {valid[SQRT_STEPS-1:0], pre_valid[2]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1 <= in_vec;
      sh <= norm_shift(in_vec.mag[0] | in_vec.mag[1] | in_vec.mag[2]);
      v2.neg  <= v1.neg;
      v2.zero <= v1.zero;
      for (int i = 0; i < 3; i++) begin
        v2.mag[i] <= v1.mag[i] << sh;
      end
      v3 <= v2;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= 64'(v2.mag[i]) * 64'(v2.mag[i]);
      end
      vp[0]   <= v3;
      remp[0] <= sq[0] + sq[1] + sq[2];
      resp[0] <= 64'd0;
    end
  end

  // one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        take;

    assign trial = resp[k] + BIT;
    assign take  = remp[k] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        vp[k+1]   <= vp[k];
        resp[k+1] <= take ? ((resp[k] >> 1) + BIT) : (resp[k] >> 1);
      end
    end

    if (k + 1 < SQRT_STEPS) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          remp[k+1] <= take ? (remp[k] - trial) : remp[k];
        end
      end
    end
  end

  assign out_valid = valid[SQRT_STEPS];
  assign out_vec   = vp[SQRT_STEPS];
  assign out_norm  = resp[SQRT_STEPS][MAG_BITS-1:0];

endmodule

>>> src/crdg_div.sv
module crdg_div import crdg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  vec_t                in_vec,
  input  logic [MAG_BITS-1:0] in_norm,
  output logic                out_valid,
  output dir_t                out_dir
);

  localparam int NUM_BITS = MAG_BITS + 14 + 1;

  logic [QUO_BITS+1:0] valid;

  logic [2:0][MAG_BITS-1:0] remp [0:QUO_BITS-1];
  logic [2:0][QUO_BITS-1:0] lowp [0:QUO_BITS-1];
  logic [2:0][QUO_BITS-1:0] qp   [0:QUO_BITS];
  logic [MAG_BITS-1:0]      np   [0:QUO_BITS-1];
  logic [2:0]               negp [0:QUO_BITS];
  logic                     zp   [0:QUO_BITS];

  logic [2:0][NUM_BITS-1:0] num;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {in_vec.mag[i], 14'd0} + NUM_BITS'(in_norm >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[QUO_BITS:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        remp[0][i] <= num[i][NUM_BITS-1:QUO_BITS];
        lowp[0][i] <= num[i][QUO_BITS-1:0];
      end
      qp[0]   <= '0;
      np[0]   <= in_norm;
      negp[0] <= in_vec.neg;
      zp[0]   <= in_vec.zero;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
    logic [2:0][MAG_BITS:0]   part;
    logic [2:0]               take;
    logic [2:0][MAG_BITS-1:0] rem_next;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        part[i]     = {remp[k][i], lowp[k][i][QUO_BITS-1]};
        take[i]     = part[i] >= {1'b0, np[k]};
        rem_next[i] = take[i] ? MAG_BITS'(part[i] - {1'b0, np[k]})
                              : MAG_BITS'(part[i]);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          qp[k+1][i] <= {qp[k][i][QUO_BITS-2:0], take[i]};
        end
        negp[k+1] <= negp[k];
        zp[k+1]   <= zp[k];
      end
    end

    if (k + 1 < QUO_BITS) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          remp[k+1] <= rem_next;
          np[k+1]   <= np[k];
          for (int i = 0; i < 3; i++) begin
            lowp[k+1][i] <= lowp[k][i] << 1;
          end
        end
      end
    end
  end

  // apply sign, zero vector gives zero
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (zp[QUO_BITS]) begin
          out_dir[i] <= 16'd0;
        end else if (negp[QUO_BITS][i]) begin
          out_dir[i] <= 16'd0 - 16'(qp[QUO_BITS][i]);
        end else begin
          out_dir[i] <= 16'(qp[QUO_BITS][i]);
        end
      end
    end
  end

  assign out_valid = valid[QUO_BITS+1];

endmodule

>>> src/crdg_rotate.sv
module crdg_rotate import crdg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  dir_t in_dir,
  input  rot_t rot,
  output logic out_valid,
  output dir_t out_dir
);

  logic [1:0] valid;
  logic signed [31:0] prod [3][3];
  logic [2:0][15:0]   dir_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= $signed(rot[i][16*j +: 16]) * $signed(in_dir[j]);
        end
      end
    end
  end

  always_comb begin
    logic signed [33:0] acc;
    logic signed [33:0] shr;
    for (int i = 0; i < 3; i++) begin
      acc = 34'(prod[i][0]) + 34'(prod[i][1]) + 34'(prod[i][2]) + 34'sd8192;
      shr = acc >>> 14;
      if (shr > 34'sd16384) begin
        dir_next[i] = 16'sd16384;
      end else if (shr < -34'sd16384) begin
        dir_next[i] = -16'sd16384;
      end else begin
        dir_next[i] = shr[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dir <= dir_next;
    end
  end

  assign out_valid = valid[1];

endmodule

>>> src/camera_ray_direction_gen_top.sv
// channel   dir  width  contents
// s_*       in   56     request: pixel_x, pixel_y, jitter_x, jitter_y
// m_*       out  48     request: dir_x, dir_y, dir_z (signed q1.14)
// cfg_*     in   48     register write, index 0..6, no read-back
//
// the pipeline runs screen math, then normalize and square root
// (one root bit per stage), division (one quotient bit per stage),
// and rotation; one request enters every cycle unless a stall holds it
// the last rotation stage is the output register
// a stall on m_tready freezes every stage at once, s_tready drops with it
// rst is synchronous and clears all valid bits and the configuration registers

`include "assert_macros.svh"

module camera_ray_direction_gen_top import crdg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // pixel_x, pixel_y, jitter_x, jitter_y
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // dir_x, dir_y, dir_z
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  // configuration registers
  logic [24:0] x_scale;
  logic [24:0] y_scale;
  logic [19:0] aspect_ratio;
  logic [19:0] focal_depth;
  rot_t        rot;

  // global stage enable: move unless the output holds an untaken result
  logic en;

  logic scr_valid, sq_valid, div_valid;
  vec_t scr_vec, sq_vec;
  logic [MAG_BITS-1:0] sq_norm;
  dir_t div_dir, rot_dir;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_scale      <= X_SCALE_RST;
      y_scale      <= Y_SCALE_RST;
      aspect_ratio <= ASPECT_RST;
      focal_depth  <= FOCAL_RST;
      rot[0]       <= ROT_X_RST;
      rot[1]       <= ROT_Y_RST;
      rot[2]       <= ROT_Z_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_SCALE: x_scale      <= cfg_data[24:0];
        REG_Y_SCALE: y_scale      <= cfg_data[24:0];
        REG_ASPECT:  aspect_ratio <= cfg_data[19:0];
        REG_FOCAL:   focal_depth  <= cfg_data[19:0];
        REG_ROT_X:   rot[0]       <= cfg_data;
        REG_ROT_Y:   rot[1]       <= cfg_data;
        REG_ROT_Z:   rot[2]       <= cfg_data;
        default: ;
      endcase
    end
  end

  // screen coordinates, saturated, as magnitude and sign
  crdg_screen u_screen (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (s_tvalid && s_tready),
    .pixel_x      (s_tdata[11:0]),
    .pixel_y      (s_tdata[23:12]),
    .jitter_x     (s_tdata[39:24]),
    .jitter_y     (s_tdata[55:40]),
    .x_scale      (x_scale),
    .y_scale      (y_scale),
    .aspect_ratio (aspect_ratio),
    .focal_depth  (focal_depth),
    .out_valid    (scr_valid),
    .out_vec      (scr_vec)
  );

  // pre-shift, sum of squares, integer square root
  crdg_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (scr_valid),
    .in_vec    (scr_vec),
    .out_valid (sq_valid),
    .out_vec   (sq_vec),
    .out_norm  (sq_norm)
  );

  // three rounded divisions by the norm
  crdg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .in_vec    (sq_vec),
    .in_norm   (sq_norm),
    .out_valid (div_valid),
    .out_dir   (div_dir)
  );

  // camera rotation, output register
  crdg_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .in_dir    (div_dir),
    .rot       (rot),
    .out_valid (m_tvalid),
    .out_dir   (rot_dir)
  );

  assign m_tdata = {rot_dir[2], rot_dir[1], rot_dir[0]};

  `ASSERT_CLK(a_ready_tracks_out, s_tready == (!m_tvalid || m_tready), "ready does not follow output")
  `ASSERT_IMPL(a_dir_x_range, m_tvalid, ($signed(m_tdata[15:0]) <= 16'sd16384 && $signed(m_tdata[15:0]) >= -16'sd16384), "dir_x out of range")
  `ASSERT_IMPL(a_dir_z_range, m_tvalid, ($signed(m_tdata[47:32]) <= 16'sd16384 && $signed(m_tdata[47:32]) >= -16'sd16384), "dir_z out of range")

endmodule

>>> sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import crdg_pkg::*;

  // ray directions expected from accepted requests, oldest first
  class ray_scoreboard;
    logic [24:0] x_scale, y_scale;
    logic [19:0] aspect, focal;
    logic [47:0] rot [3];
    logic [47:0] pending_dirs [$];
    int errors;

    function void reset_regs();
      x_scale = X_SCALE_RST;
      y_scale = Y_SCALE_RST;
      aspect  = ASPECT_RST;
      focal   = FOCAL_RST;
      rot[0]  = ROT_X_RST;
      rot[1]  = ROT_Y_RST;
      rot[2]  = ROT_Z_RST;
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] val);
      case (idx)
        REG_X_SCALE: x_scale = val[24:0];
        REG_Y_SCALE: y_scale = val[24:0];
        REG_ASPECT:  aspect  = val[19:0];
        REG_FOCAL:   focal   = val[19:0];
        REG_ROT_X:   rot[0]  = val;
        REG_ROT_Y:   rot[1]  = val;
        REG_ROT_Z:   rot[2]  = val;
        default: ;
      endcase
    endfunction

    // floor divide by 2^k; >>> on longint floors
    function longint fshift(longint v, int k);
      return v >>> k;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint screen(logic [11:0] pix, logic [15:0] jit, logic [24:0] sc);
      logic [63:0] u, t;
      u = ({52'd0, pix} << 16) + {48'd0, jit};
      t = (u * {39'd0, sc} + 64'd8388608) >> 24;
      return longint'(t) - 65536;
    endfunction

    function logic [63:0] root(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void note_request(logic [55:0] req);
      longint v [3], d [3], acc, q, e;
      logic [63:0] m [3], mx, ss, n;
      logic [47:0] dirs;
      v[0] = screen(req[11:0], req[39:24], x_scale);
      v[0] = clip(fshift(v[0] * longint'(aspect) + 32768, 16), -64'sd2147483648, 2147483647);
      v[1] = clip(screen(req[23:12], req[55:40], y_scale), -64'sd2147483648, 2147483647);
      v[2] = -longint'(focal);
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = v[i] < 0 ? -v[i] : v[i];
        if (m[i] > mx) mx = m[i];
        d[i] = 0;
      end
      if (mx != 0) begin
        while (mx < (64'd1 << 30)) begin
          mx = mx << 1;
          for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        ss = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        n = root(ss);
        for (int i = 0; i < 3; i++) begin
          q = longint'(((m[i] << 14) + (n >> 1)) / n);
          if (q > 16384) q = 16384;
          d[i] = v[i] < 0 ? -q : q;
        end
      end
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) begin
          e = longint'(signed'(rot[i][16*j +: 16]));
          acc += e * d[j];
        end
        acc = clip(fshift(acc + 8192, 14), -16384, 16384);
        dirs[16*i +: 16] = acc[15:0];
      end
      pending_dirs.push_back(dirs);
    endfunction

    function void check_result(logic [47:0] got);
      logic [47:0] exp_dirs;
      string names [3] = '{"dir_x", "dir_y", "dir_z"};
      if (pending_dirs.size() == 0) begin
        $error("unexpected ray direction %h", got);
        errors++;
        return;
      end
      exp_dirs = pending_dirs.pop_front();
      for (int i = 0; i < 3; i++)
        if (got[16*i +: 16] !== exp_dirs[16*i +: 16]) begin
          $error("%s expected %0d actual %0d", names[i],
                 signed'(exp_dirs[16*i +: 16]), signed'(got[16*i +: 16]));
          errors++;
        end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // pixel_x, pixel_y, jitter_x, jitter_y
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // dir_x, dir_y, dir_z
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  ray_scoreboard sb = new();
  int hold_off;        // long receiver stall, set by the stimulus
  bit idle_free;       // stretch with no random idling on either side

  camera_ray_direction_gen_top i_dut (.*);

  always #5 clk = ~clk;

  // hard stop well beyond the slowest correct run
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // receiver: random idling, plus one long hold-off when asked
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= idle_free || ($urandom_range(99) >= 20);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // one request; valid stays high across back-to-back requests
  task automatic send_ray(logic [11:0] px, logic [11:0] py, logic [15:0] jx, logic [15:0] jy);
    while (!idle_free && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {jy, jx, py, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request({jy, jx, py, px});
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_dirs.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_row();
    return {16'($urandom_range(65535)), 16'($urandom_range(65535)),
            16'($urandom_range(65535))};
  endfunction

  task automatic random_rays(int count);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(3))
        0: send_ray(12'($urandom), 12'($urandom), 16'($urandom), 16'($urandom));
        1: send_ray(12'($urandom_range(63)), 12'($urandom_range(63)),
                    16'($urandom), 16'($urandom));
        2: send_ray(12'(4095 - $urandom_range(3)), 12'($urandom_range(3)),
                    16'hFFFF, 16'h0000);
        default: send_ray(12'($urandom_range(2048, 2047)), 12'($urandom_range(2048, 2047)),
                          16'($urandom), 16'($urandom));
      endcase
    end
  endtask

  initial begin
    sb.reset_regs();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes at reset settings
    idle_free = 1;
    send_ray(12'd0, 12'd0, 16'd0, 16'd0);
    send_ray(12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF);
    send_ray(12'hFFF, 12'd0, 16'hFFFF, 16'd0);
    send_ray(12'd0, 12'hFFF, 16'd0, 16'hFFFF);
    send_ray(12'h555, 12'hAAA, 16'h5555, 16'hAAAA);
    send_ray(12'hAAA, 12'h555, 16'hAAAA, 16'h5555);
    drain();

    // zero-length vector: screen center with zero focal depth
    write_reg(REG_X_SCALE, 48'd8192);
    write_reg(REG_Y_SCALE, 48'd8192);
    write_reg(REG_FOCAL, 48'd0);
    write_reg(3'd7, 48'hFFFF_FFFF_FFFF);  // unused index, ignored
    send_ray(12'd2048, 12'd2048, 16'd0, 16'd0);
    send_ray(12'd2047, 12'd2048, 16'hFFFF, 16'd0);
    send_ray(12'd2048, 12'd2047, 16'd0, 16'hFFFF);
    drain();

    // saturating screen coordinates: maximal scales and aspect
    write_reg(REG_X_SCALE, 48'h1FF_FFFF);
    write_reg(REG_Y_SCALE, 48'h1FF_FFFF);
    write_reg(REG_ASPECT, 48'hFFFFF);
    write_reg(REG_FOCAL, 48'hFFFFF);
    send_ray(12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF);
    send_ray(12'd0, 12'd0, 16'd0, 16'd0);
    send_ray(12'd1, 12'd1, 16'd0, 16'd0);
    drain();

    // non-unit rotation saturates the outputs
    write_reg(REG_ROT_X, 48'h7FFF_7FFF_7FFF);
    write_reg(REG_ROT_Y, 48'h8000_8000_8000);
    write_reg(REG_ROT_Z, 48'h7FFF_8000_7FFF);
    write_reg(REG_ASPECT, 48'd0);
    send_ray(12'hFFF, 12'd0, 16'd0, 16'd0);
    send_ray(12'd0, 12'hFFF, 16'd0, 16'd0);
    send_ray(12'd100, 12'd3000, 16'h8000, 16'h1234);
    drain();
    idle_free = 0;

    // random phases over random settings, reset values among them
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0) begin
        write_reg(REG_X_SCALE, 48'(X_SCALE_RST));
        write_reg(REG_Y_SCALE, 48'(Y_SCALE_RST));
        write_reg(REG_ASPECT, 48'(ASPECT_RST));
        write_reg(REG_FOCAL, 48'(FOCAL_RST));
        write_reg(REG_ROT_X, ROT_X_RST);
        write_reg(REG_ROT_Y, ROT_Y_RST);
        write_reg(REG_ROT_Z, ROT_Z_RST);
      end else begin
        write_reg(REG_X_SCALE, 48'($urandom_range(3) == 0 ? $urandom_range(25'h1FF_FFFF)
                                                          : $urandom_range(2, 16384)));
        write_reg(REG_Y_SCALE, 48'($urandom_range(3) == 0 ? $urandom_range(25'h1FF_FFFF)
                                                          : $urandom_range(2, 16384)));
        write_reg(REG_ASPECT, 48'($urandom_range(20'hFFFFF)));
        write_reg(REG_FOCAL, 48'($urandom_range(3) == 0 ? 0 : $urandom_range(20'hFFFFF)));
        write_reg(REG_ROT_X, rand_row());
        write_reg(REG_ROT_Y, rand_row());
        write_reg(REG_ROT_Z, rand_row());
      end
      if (ph == 3) idle_free = 1;
      if (ph == 5) hold_off = 300;   // block fills and drops s_tready
      random_rays(160);
      idle_free = 0;
      drain();
    end

    if (sb.errors == 0 && sb.pending_dirs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
